// File: hdl/fchd_pkg.sv
// Shared types and fixed constants for the foot contact hysteresis detector.
package fchd_pkg;

  // One sample word after the front has classified it
  typedef struct packed {
    logic        side;
    logic        foot;
    logic        close;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic [31:0] gnd;
    logic [15:0] dt;
  } fchd_item_t;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    BK_IDLE,
    BK_SQ,
    BK_ROOT,
    BK_MEAN,
    BK_MEAN2,
    BK_VAR,
    BK_VAR2,
    BK_DEC,
    BK_DIV
  } fchd_bk_state_t;

  // How the weight of the result is formed
  typedef enum logic [1:0] {
    W_ZERO,
    W_ONE,
    W_RAMP
  } fchd_wmode_t;

  localparam logic [12:0] EMA_GAIN     = 13'd5243;
  localparam logic [12:0] RELEASE_TIME = 13'd6554;
  localparam logic [30:0] IK_DELAY     = 31'd3277;
  localparam logic [16:0] WEIGHT_ONE   = 17'd65536;
  localparam logic [30:0] PLANT_MAX    = 31'h7FFFFFFF;
  localparam logic [19:0] THR_RESET    = 20'd3277;
  localparam logic        REG_THRESHOLD = 1'b0;

endpackage

// File: hdl/fchd_front.sv
// Front end: takes input words, picks the foot and flags ground proximity.
module fchd_front #(
  parameter int NUM_FEET = 2
) (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_side,
  input  logic [31:0]        in_foot_x,
  input  logic [31:0]        in_foot_y,
  input  logic [31:0]        in_foot_z,
  input  logic [31:0]        in_vel_x,
  input  logic [31:0]        in_vel_y,
  input  logic [31:0]        in_vel_z,
  input  logic [31:0]        in_ground_level,
  input  logic [15:0]        in_frame_time,
  input  logic [19:0]        threshold,
  input  logic               q_full,
  output logic               q_push,
  output fchd_pkg::fchd_item_t q_item
);
  import fchd_pkg::*;

  logic [32:0] height_diff;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // height above ground, one bit wider so it cannot wrap
  assign height_diff = {in_foot_y[31], in_foot_y} - {in_ground_level[31], in_ground_level};

  always_comb begin
    q_item.side  = in_side;
    q_item.foot  = (NUM_FEET > 1) ? in_side : 1'b0;
    q_item.close = $signed(height_diff) <= $signed({13'd0, threshold});
    q_item.px    = in_foot_x;
    q_item.py    = in_foot_y;
    q_item.pz    = in_foot_z;
    q_item.vx    = in_vel_x;
    q_item.vy    = in_vel_y;
    q_item.vz    = in_vel_z;
    q_item.gnd   = in_ground_level;
    q_item.dt    = in_frame_time;
  end

endmodule

// File: hdl/fchd_queue.sv
// Two-entry word queue between the front and back ends.
module fchd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  fchd_pkg::fchd_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output fchd_pkg::fchd_item_t pop_item
);
  import fchd_pkg::*;

  fchd_item_t  mem_r [2];
  logic        wptr_r, rptr_r;
  logic [1:0]  cnt_r;

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign pop_item  = mem_r[rptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_item;
  end

endmodule

// File: hdl/fchd_back.sv
// Back end: speed root, EMA statistics, Schmitt trigger and result register.
module fchd_back #(
  parameter int NUM_FEET  = 2,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  fchd_pkg::fchd_item_t q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_side,
  output logic                 out_locked,
  output logic [16:0]          out_lock_weight,
  output logic [31:0]          out_target_x,
  output logic [31:0]          out_target_y,
  output logic [31:0]          out_target_z,
  output logic [30:0]          out_plant_time
);
  import fchd_pkg::*;

  localparam int FW = (NUM_FEET > 1) ? $clog2(NUM_FEET) : 1;
  localparam logic [31:0] ZERO_SPEED   = 32'(((64'd2 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [31:0] REST_SPEED   = 32'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [31:0] ACTIVE_SPEED = 32'(((64'd8 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [31:0] REST_VAR     = 32'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [31:0] ACTIVE_VAR   = 32'(((64'd5 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [63:0] TERM_HALF    = 64'd1 << (FRAC_BITS - 1);
  // reciprocal of the release time, scaled by 2^40
  localparam logic [27:0] RECIP        = 28'((64'd1 << 40) / 64'd6554);

  // per-foot state
  logic        lock_a  [NUM_FEET];
  logic [30:0] plant_a [NUM_FEET];
  logic [17:0] rt_a    [NUM_FEET];
  logic [31:0] mean_a  [NUM_FEET];
  logic [31:0] var_a   [NUM_FEET];
  logic [31:0] posx_a  [NUM_FEET];
  logic [31:0] posy_a  [NUM_FEET];
  logic [31:0] posz_a  [NUM_FEET];

  fchd_bk_state_t state_r, state_nxt;
  fchd_item_t     item_r;
  logic [3:0]     cnt_r;
  logic [63:0]    acc_r;
  logic [63:0]    rad_r;
  logic [35:0]    rem_r;
  logic [31:0]    root_r;
  logic [31:0]    speed_r;
  logic [46:0]    mprod_r;
  logic [31:0]    mean_r;
  logic [31:0]    m1_r, m2_r;
  logic [63:0]    prod_r;
  logic [46:0]    vprod_r;
  logic [31:0]    varn_r;
  logic           nl_r;
  logic [30:0]    npt_r;
  logic [17:0]    nrt_r;
  fchd_wmode_t    wmode_r;
  logic [56:0]    divp_r;
  logic           out_valid_r;
  logic           commit;

  logic [FW-1:0]  fi;
  logic [31:0]    vsel, vmag;
  logic [67:0]    st1, st2;
  logic [31:0]    speed_c;
  logic [32:0]    d_sp;
  logic [33:0]    mean_c;
  logic [32:0]    d1, d2;
  logic [63:0]    tsum;
  logic [31:0]    term;
  logic [32:0]    d_var;
  logic [33:0]    varn_c;
  logic           rest, active;
  logic           nl_c;
  logic [30:0]    npt_c;
  logic [17:0]    nrt_c;
  fchd_wmode_t    wmode_c;
  logic [31:0]    ptsum;
  logic [28:0]    xnum;
  logic [16:0]    q0;
  logic [29:0]    rchk;
  logic [16:0]    qf;
  logic [16:0]    weight;

  // one restoring square-root step: two radicand bits in, one root bit out
  function automatic logic [67:0] sqrt_step(input logic [35:0] rem,
                                            input logic [31:0] root,
                                            input logic [1:0]  bits2);
    logic [35:0] trial;
    logic [35:0] sub;
    trial = {rem[33:0], bits2};
    sub   = {2'b00, root, 2'b01};
    if (trial >= sub) sqrt_step = {trial - sub, root[30:0], 1'b1};
    else              sqrt_step = {trial, root[30:0], 1'b0};
  endfunction

  assign fi = FW'(item_r.foot);

  // velocity component magnitude for the squaring pass
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    vsel = item_r.vx;
      2'd1:    vsel = item_r.vy;
      default: vsel = item_r.vz;
    endcase
    vmag = vsel[31] ? (32'd0 - vsel) : vsel;
  end

  assign st1 = sqrt_step(rem_r, root_r, rad_r[63:62]);
  assign st2 = sqrt_step(st1[67:32], st1[31:0], rad_r[61:60]);

  // speed with dead zone
  assign speed_c = (root_r < ZERO_SPEED) ? 32'd0 : root_r;
  assign d_sp    = {1'b0, speed_c} - {1'b0, mean_a[fi]};

  // mean update and the two deviations (old mean and new mean)
  assign mean_c = {2'b00, mean_a[fi]} +
                  34'($signed(47'(mprod_r + 47'd32768)) >>> 16);
  assign d1 = {1'b0, speed_r} - {1'b0, mean_a[fi]};
  assign d2 = {1'b0, speed_r} - {1'b0, mean_c[31:0]};

  // variance term, rounded and saturated
  assign tsum  = (prod_r + TERM_HALF) >> FRAC_BITS;
  assign term  = (tsum > 64'hFFFFFFFF) ? 32'hFFFFFFFF : tsum[31:0];
  assign d_var = {1'b0, term} - {1'b0, var_a[fi]};

  assign varn_c = {2'b00, var_a[fi]} +
                  34'($signed(47'(vprod_r + 47'd32768)) >>> 16);

  // Schmitt trigger decision
  assign rest   = (varn_c[31:0] < REST_VAR) && (speed_r < REST_SPEED);
  assign active = (speed_r > ACTIVE_SPEED) || (varn_c[31:0] > ACTIVE_VAR);
  assign ptsum  = {1'b0, plant_a[fi]} + {16'd0, item_r.dt};

  always_comb begin
    nl_c    = lock_a[fi];
    npt_c   = plant_a[fi];
    nrt_c   = rt_a[fi];
    wmode_c = W_ZERO;
    if (lock_a[fi]) begin
      if (active || !item_r.close) begin
        nl_c  = 1'b0;
        nrt_c = {5'd0, RELEASE_TIME};
      end else begin
        wmode_c = W_ONE;
        nrt_c   = 18'd0;
        npt_c   = (ptsum > {1'b0, PLANT_MAX}) ? PLANT_MAX : ptsum[30:0];
      end
    end else if (item_r.close && rest) begin
      nl_c    = 1'b1;
      wmode_c = W_ONE;
      nrt_c   = 18'd0;
      npt_c   = 31'd0;
    end else if ($signed(rt_a[fi]) > 18'sd0) begin
      nrt_c   = rt_a[fi] - {2'b00, item_r.dt};
      wmode_c = W_RAMP;
    end
  end

  // ramp weight: reciprocal multiply with one correction step
  assign xnum   = {nrt_c[12:0], 16'd0};
  assign q0     = divp_r[56:40];
  assign rchk   = {1'b0, nrt_r[12:0], 16'd0} - (30'(q0) * 30'(RELEASE_TIME));
  assign qf     = (rchk >= {17'd0, RELEASE_TIME}) ? q0 + 17'd1 : q0;

  always_comb begin
    case (wmode_r)
      W_ONE:   weight = WEIGHT_ONE;
      W_RAMP: begin
        if ($signed(nrt_r) <= 18'sd0)  weight = 17'd0;
        else if (qf > WEIGHT_ONE)      weight = WEIGHT_ONE;
        else                           weight = qf;
      end
      default: weight = 17'd0;
    endcase
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else        state_r <= state_nxt;
  end

  // next state and handshakes
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    commit    = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = BK_SQ;
        end
      end
      BK_SQ:    if (cnt_r == 4'd2)  state_nxt = BK_ROOT;
      BK_ROOT:  if (cnt_r == 4'd15) state_nxt = BK_MEAN;
      BK_MEAN:  state_nxt = BK_MEAN2;
      BK_MEAN2: state_nxt = BK_VAR;
      BK_VAR:   state_nxt = BK_VAR2;
      BK_VAR2:  state_nxt = BK_DEC;
      BK_DEC:   state_nxt = BK_DIV;
      BK_DIV: begin
        if (!out_valid_r || out_ready) begin
          commit    = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        item_r <= q_item;
        cnt_r  <= 4'd0;
        acc_r  <= 64'd0;
      end
      BK_SQ: begin
        if (cnt_r == 4'd2) begin
          rad_r  <= acc_r + vmag * vmag;
          rem_r  <= 36'd0;
          root_r <= 32'd0;
          cnt_r  <= 4'd0;
        end else begin
          acc_r <= acc_r + vmag * vmag;
          cnt_r <= cnt_r + 4'd1;
        end
      end
      BK_ROOT: begin
        rem_r  <= st2[67:32];
        root_r <= st2[31:0];
        rad_r  <= {rad_r[59:0], 4'd0};
        cnt_r  <= cnt_r + 4'd1;
      end
      BK_MEAN: begin
        speed_r <= speed_c;
        mprod_r <= $signed({{14{d_sp[32]}}, d_sp}) * $signed({34'd0, EMA_GAIN});
      end
      BK_MEAN2: begin
        mean_r <= mean_c[31:0];
        m1_r   <= d1[32] ? 32'(33'd0 - d1) : d1[31:0];
        m2_r   <= 32'(d2[32] ? (33'd0 - d2) : d2);
      end
      BK_VAR: begin
        prod_r <= m1_r * m2_r;
      end
      BK_VAR2: begin
        vprod_r <= $signed({{14{d_var[32]}}, d_var}) * $signed({34'd0, EMA_GAIN});
      end
      BK_DEC: begin
        varn_r  <= varn_c[31:0];
        nl_r    <= nl_c;
        npt_r   <= npt_c;
        nrt_r   <= nrt_c;
        wmode_r <= wmode_c;
        divp_r  <= xnum * RECIP;
      end
      default: ;
    endcase
  end

  // per-foot state, written when the result is handed over
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_FEET; i++) begin
        lock_a[i]  <= 1'b0;
        plant_a[i] <= 31'd0;
        rt_a[i]    <= 18'd0;
        mean_a[i]  <= 32'd0;
        var_a[i]   <= 32'd0;
        posx_a[i]  <= 32'd0;
        posy_a[i]  <= 32'd0;
        posz_a[i]  <= 32'd0;
      end
    end else if (commit) begin
      lock_a[fi]  <= nl_r;
      plant_a[fi] <= npt_r;
      rt_a[fi]    <= nrt_r;
      mean_a[fi]  <= mean_r;
      var_a[fi]   <= varn_r;
      if (nl_r && !lock_a[fi]) begin
        posx_a[fi] <= item_r.px;
        posy_a[fi] <= item_r.gnd;
        posz_a[fi] <= item_r.pz;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (commit) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_side        <= item_r.side;
      out_locked      <= nl_r;
      out_lock_weight <= weight;
      out_plant_time  <= npt_r;
      if (nl_r && lock_a[fi] && (npt_r > IK_DELAY)) begin
        out_target_x <= posx_a[fi];
        out_target_y <= posy_a[fi];
        out_target_z <= posz_a[fi];
      end else begin
        out_target_x <= item_r.px;
        out_target_y <= item_r.py;
        out_target_z <= item_r.pz;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: hdl/foot_contact_hysteresis_detector.sv
// Foot contact detector: front end, word queue, back end and config register.
// The back end handles one word at a time: the queue pop, the squaring pass, the
// two-bit-per-cycle square root and 6 update steps, the last of which waits while
// an earlier result is still held without out_ready; then it takes the next word.
// The two-entry queue lets the input side take words while the back end works.
// Reset (rst_n low, synchronous): all foot state zero, threshold 3277, queue empty.
module foot_contact_hysteresis_detector #(
  parameter int NUM_FEET  = 2,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_side,
  input  logic [31:0] in_foot_x,
  input  logic [31:0] in_foot_y,
  input  logic [31:0] in_foot_z,
  input  logic [31:0] in_vel_x,
  input  logic [31:0] in_vel_y,
  input  logic [31:0] in_vel_z,
  input  logic [31:0] in_ground_level,
  input  logic [15:0] in_frame_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_side,
  output logic        out_locked,
  output logic [16:0] out_lock_weight,
  output logic [31:0] out_target_x,
  output logic [31:0] out_target_y,
  output logic [31:0] out_target_z,
  output logic [30:0] out_plant_time,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fchd_pkg::*;

  logic [19:0] thr_r;
  logic        q_full, q_push, q_valid, q_pop;
  fchd_item_t  push_item, pop_item;

  // threshold register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= THR_RESET;
    else if (psel && penable && pwrite && (paddr[2] == REG_THRESHOLD)) thr_r <= pwdata[19:0];
  end
  assign prdata = (paddr[2] == REG_THRESHOLD) ? {12'd0, thr_r} : 32'd0;

  fchd_front #(.NUM_FEET(NUM_FEET)) u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_side         (in_side),
    .in_foot_x       (in_foot_x),
    .in_foot_y       (in_foot_y),
    .in_foot_z       (in_foot_z),
    .in_vel_x        (in_vel_x),
    .in_vel_y        (in_vel_y),
    .in_vel_z        (in_vel_z),
    .in_ground_level (in_ground_level),
    .in_frame_time   (in_frame_time),
    .threshold       (thr_r),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (push_item)
  );

  fchd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_item  (pop_item)
  );

  fchd_back #(.NUM_FEET(NUM_FEET), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (pop_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_side        (out_side),
    .out_locked      (out_locked),
    .out_lock_weight (out_lock_weight),
    .out_target_x    (out_target_x),
    .out_target_y    (out_target_y),
    .out_target_z    (out_target_z),
    .out_plant_time  (out_plant_time)
  );

endmodule
